// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by rns_modular_mul_add_unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");

// expression must never be true out of reset
`define ASSERT_NEVER(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("forbidden condition");

`endif

// ----- design/rmma_pkg.sv -----
// ----------------------------------------------------------------------------
// rmma_pkg
// Types, constants and modular helpers of the RNS multiply-add unit.
// ----------------------------------------------------------------------------
package rmma_pkg;

   localparam int DataW   = 64;
   localparam int ValueW  = 63;
   localparam int LimbW   = 3;
   localparam int FuncW   = 2;
   localparam int CsrIdxW = 3;

   localparam logic [FuncW-1:0] FUNC_ADD = 2'd0;
   localparam logic [FuncW-1:0] FUNC_MUL = 2'd1;
   localparam logic [FuncW-1:0] FUNC_MAC = 2'd2;

   // one reduce step per operand bit, two steps per multiplier bit, one final add
   localparam int RedSteps   = DataW;
   localparam int MulSteps   = 2 * DataW;
   localparam int PipeStages = RedSteps + MulSteps + 1;

   typedef struct packed {
      logic [FuncW-1:0] func;
      logic [LimbW-1:0] limb;
      logic [DataW-1:0] a;
      logic [DataW-1:0] b;
      logic [DataW-1:0] c;
   } req_type;

   typedef struct packed {
      logic [ValueW-1:0] value;
      logic [LimbW-1:0]  limb_out;
      logic              skipped;
   } rsp_type;

   typedef struct packed {
      logic [FuncW-1:0] func;
      logic [LimbW-1:0] limb;
      logic             skip;
      logic [DataW-1:0] q;
      logic [DataW-1:0] sa;
      logic [DataW-1:0] sb;
      logic [DataW-1:0] sc;
      logic [DataW-1:0] ra;
      logic [DataW-1:0] rb;
      logic [DataW-1:0] rc;
      logic [DataW-1:0] acc;
   } pipe_type;

   function automatic logic [DataW-1:0] add_mod(input logic [DataW-1:0] x,
                                                 input logic [DataW-1:0] y,
                                                 input logic [DataW-1:0] q);
      logic [DataW-1:0] s;
      s = x + y;
      return (s >= q) ? s - q : s;
   endfunction

   function automatic logic [DataW-1:0] red_step(input logic [DataW-1:0] r,
                                                  input logic             bit_in,
                                                  input logic [DataW-1:0] q);
      logic [DataW-1:0] t;
      t = {r[DataW-2:0], bit_in};
      return (t >= q) ? t - q : t;
   endfunction

endpackage

// ----- design/rmma_pipe.sv -----
// ----------------------------------------------------------------------------
// rmma_pipe
// Datapath pipeline: bit-serial operand reduction, double-and-add
// modular multiply and final modular add, one step per stage.
// ----------------------------------------------------------------------------
module rmma_pipe (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_vld,
   input  rmma_pkg::req_type in_req,
   input  logic [63:0]      in_q,
   output logic             out_vld,
   output rmma_pkg::rsp_type out_rsp
);
   import rmma_pkg::*;

   logic [PipeStages:0] vld_ff;
   pipe_type            dat_ff [0:PipeStages];
   pipe_type            dat_in;

   always_comb begin
      dat_in.func = in_req.func;
      dat_in.limb = in_req.limb;
      dat_in.q    = in_q;
      dat_in.skip = (in_q == '0) || in_q[DataW-1];
      dat_in.sa   = in_req.a;
      dat_in.sb   = in_req.b;
      dat_in.sc   = in_req.c;
      dat_in.ra   = '0;
      dat_in.rb   = '0;
      dat_in.rc   = '0;
      dat_in.acc  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dat_ff[0] <= dat_in;
      end
   end

   for (genvar s = 1; s <= PipeStages; s++) begin : g_stg
      pipe_type nx_in;
      if (s <= RedSteps) begin : g_red
         always_comb begin
            nx_in    = dat_ff[s-1];
            nx_in.ra = red_step(dat_ff[s-1].ra, dat_ff[s-1].sa[DataW-1], dat_ff[s-1].q);
            nx_in.rb = red_step(dat_ff[s-1].rb, dat_ff[s-1].sb[DataW-1], dat_ff[s-1].q);
            nx_in.rc = red_step(dat_ff[s-1].rc, dat_ff[s-1].sc[DataW-1], dat_ff[s-1].q);
            nx_in.sa = {dat_ff[s-1].sa[DataW-2:0], 1'b0};
            nx_in.sb = {dat_ff[s-1].sb[DataW-2:0], 1'b0};
            nx_in.sc = {dat_ff[s-1].sc[DataW-2:0], 1'b0};
         end
      end else if (s <= RedSteps + MulSteps) begin : g_mul
         localparam int Step = (s - RedSteps - 1) / 2;
         localparam int Ph   = (s - RedSteps - 1) % 2;
         always_comb begin
            nx_in = dat_ff[s-1];
            if (Ph == 0) begin
               nx_in.acc = add_mod(dat_ff[s-1].acc, dat_ff[s-1].acc, dat_ff[s-1].q);
            end else if (dat_ff[s-1].rb[DataW-1-Step]) begin
               nx_in.acc = add_mod(dat_ff[s-1].acc, dat_ff[s-1].ra, dat_ff[s-1].q);
            end
         end
      end else begin : g_fin
         always_comb begin
            nx_in = dat_ff[s-1];
            case (dat_ff[s-1].func)
               FUNC_ADD: nx_in.acc = add_mod(dat_ff[s-1].ra, dat_ff[s-1].rc, dat_ff[s-1].q);
               FUNC_MUL: nx_in.acc = dat_ff[s-1].acc;
               default:  nx_in.acc = add_mod(dat_ff[s-1].acc, dat_ff[s-1].rc, dat_ff[s-1].q);
            endcase
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dat_ff[s] <= nx_in;
         end
      end
   end

   assign out_vld          = vld_ff[PipeStages];
   assign out_rsp.value    = dat_ff[PipeStages].skip ? '0 : dat_ff[PipeStages].acc[ValueW-1:0];
   assign out_rsp.limb_out = dat_ff[PipeStages].limb;
   assign out_rsp.skipped  = dat_ff[PipeStages].skip;

endmodule

// ----- design/rns_modular_mul_add_unit.sv -----
// ----------------------------------------------------------------------------
// rns_modular_mul_add_unit
// RNS modular multiply-add: (a+c), (a*b) or (a*b+c) mod the limb modulus.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready carry one coefficient transaction (func, limb, a, b, c).
//   rsp_valid/rsp_ready return one result transaction per request, in order.
//   csr_we/csr_index/csr_wdata write modulus_0..modulus_5; write only when idle.
// Pipeline: the input stage loads at acceptance, then 64 bit-serial reduction
//   stages, 128 double/add stages of the modular multiply, one final add stage
//   and the output buffer.
// Throughput: one transaction per cycle while the receiver takes results.
// Reset clears all valid bits and the moduli and empties the output buffer (all limbs
//   skip until written).
// Stall: a two-entry output buffer takes results; when it is full the whole
//   pipeline holds and req_ready drops, nothing is lost or repeated.
// Limbs with a zero modulus or bit 63 set return value 0 and skipped 1.
// ----------------------------------------------------------------------------
module rns_modular_mul_add_unit #(
   parameter int LIMBS = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  rmma_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output rmma_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [rmma_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [rmma_pkg::DataW-1:0]         csr_wdata
);
   import rmma_pkg::*;

   `include "assert_macros.svh"

   localparam int LimbIdxW = (LIMBS > 1) ? $clog2(LIMBS) : 1;

   logic [DataW-1:0] mod_ff [0:LIMBS-1];
   logic [DataW-1:0] q_sel;
   logic             en;
   logic             pipe_vld;
   rsp_type          pipe_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LIMBS; i++) begin
            mod_ff[i] <= '0;
         end
      end else if (csr_we && (csr_index < CsrIdxW'(LIMBS))) begin
         mod_ff[csr_index[LimbIdxW-1:0]] <= csr_wdata;
      end
   end

   always_comb begin
      q_sel = '0;
      if (req_data.limb < LimbW'(LIMBS)) begin
         q_sel = mod_ff[req_data.limb[LimbIdxW-1:0]];
      end
   end

   // output buffer
   rsp_type    buf_ff [0:1];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign en        = (cnt_ff != 2'd2);
   assign req_ready = en;
   assign push      = en && pipe_vld;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = buf_ff[rd_ptr_ff];

   rmma_pipe u_pipe (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (req_valid),
      .in_req  (req_data),
      .in_q    (q_sel),
      .out_vld (pipe_vld),
      .out_rsp (pipe_rsp)
   );

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= pipe_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   `ASSERT_NEVER(a_cnt_range, cnt_ff == 2'd3)
   `ASSERT_CLK(a_full_holds, (cnt_ff == 2'd2) |-> !req_ready)
   `ASSERT_CLK(a_skip_zero, (rsp_valid && rsp_data.skipped) |-> (rsp_data.value == '0))
   `ASSERT_CLK(a_cnt_track, (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 2'd1))

endmodule
